>>> rtl/mssp_pkg.sv
// ----------------------------------------------------------------------------
// mssp_pkg: shared types and codes for the multi-stack shared pool
// Transaction payloads, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package mssp_pkg;

  localparam int STACK_NUM_W = 9;   // stack number field, counted from one
  localparam int IN_TAG_W    = 16;  // tag field on the request channel
  localparam int OUT_CNT_W   = 11;  // total and peak fields on the response
  localparam int LIMIT_W     = 11;  // total_limit register
  localparam int CFG_DATA_W  = 11;  // widest configuration register
  localparam int CFG_IDX_W   = 1;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STACKS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LIMIT   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [STACK_NUM_W-1:0] STACKS_IN_USE_RST = 9'd256;
  localparam logic [LIMIT_W-1:0]     TOTAL_LIMIT_RST   = 11'd1024;

  typedef struct packed {
    logic                   command;
    logic [STACK_NUM_W-1:0] stack_number;
    logic [IN_TAG_W-1:0]    item_tag;
  } req_t;

  typedef struct packed {
    logic                 error_seen;
    logic [OUT_CNT_W-1:0] total_held;
    logic [OUT_CNT_W-1:0] peak_held;
    logic                 all_clear;
  } rsp_t;

endpackage

>>> rtl/mssp_ram.sv
// ----------------------------------------------------------------------------
// mssp_ram: simple dual-port synchronous RAM
// One write port, one read port with enable; read data registered.
// ----------------------------------------------------------------------------
module mssp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 27
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data between read enables
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/multi_stack_shared_pool_core.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_core: linked LIFO stacks over one shared node pool
//
// Requests arrive on req (valid/ready) carrying a command (push or pop),
// a stack number counted from one and an item tag. Each request produces
// exactly one response on rsp (valid/ready): sticky error flag, total held,
// peak held and an all-clear indication.
// Sequencing: a pop of a nonempty stack with no error set loads the
// response register from the pop state, matching or not, after reading the
// top pointer and then that node's tag and link; other requests do so from
// the read state. Requests are taken in idle. One request is in flight.
// The response register decouples the two sides: a new request is taken
// while an earlier response still waits. If a request completes while the
// response register is still full, its result is held pending and no new
// request is taken until the receiver drains the register.
// Configuration: cfg_we/cfg_index/cfg_data write stacks_in_use (index 0)
// and total_limit (index 1) without handshake; write only while idle.
// Reset (synchronous, active high) empties every stack, clears counters,
// the error flag and the free list, and restores the register defaults.
// The node and top-pointer RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_core #(
  parameter int MAX_STACKS = 256,
  parameter int POOL_NODES = 1024,
  parameter int TAG_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  mssp_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output mssp_pkg::rsp_t                    rsp,
  input  logic                              cfg_we,
  input  logic [mssp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mssp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mssp_pkg::*;

  localparam int STK_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int CNT_W  = $clog2(POOL_NODES + 1);
  localparam int LIM_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  // Node word: {link is empty marker, link index, tag}
  localparam int NWORD_W = 1 + NODE_W + TAG_BITS;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state, state_next;

  // Configuration registers
  logic [STACK_NUM_W-1:0] stacks_in_use;
  logic [LIMIT_W-1:0]     total_limit;

  // Latched transaction
  logic                cmd_q;
  logic [STK_W-1:0]    s_q;
  logic                bad_q;
  logic [TAG_BITS-1:0] tag_q;

  // Pool and counter state
  logic                  err;
  logic [CNT_W-1:0]      total, peak;
  logic                  free_none;
  logic [NODE_W-1:0]     free_idx;
  logic [CNT_W-1:0]      never_used;
  logic [MAX_STACKS-1:0] nonempty;

  // Pending response, waiting for the response register
  logic pend;

  // RAM ports
  logic               top_we, top_re;
  logic [STK_W-1:0]   top_waddr;
  logic [NODE_W-1:0]  top_wdata, top_rdata;
  logic               node_we, node_re;
  logic [NODE_W-1:0]  node_waddr, node_raddr;
  logic [NWORD_W-1:0] node_wdata, node_rdata;

  logic                rd_none;
  logic [NODE_W-1:0]   rd_below;
  logic [TAG_BITS-1:0] rd_tag;

  logic                   accept;
  logic [STACK_NUM_W-1:0] s_num;
  logic                   range_bad;
  logic                   done, fail, push_ok, pop_ok, use_free;
  logic [NODE_W-1:0]      new_nd;
  logic                   err_next;
  logic [CNT_W-1:0]       total_next, peak_next;
  logic                   slot_free;
  rsp_t                   rsp_done, rsp_pend;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE) && !pend;
  assign slot_free = !rsp_valid || rsp_ready;

  // Stack number is checked against zero, the register and the build size
  assign s_num     = req.stack_number - STACK_NUM_W'(1);
  assign range_bad = (req.stack_number == '0) ||
                     (req.stack_number > stacks_in_use) ||
                     (32'(req.stack_number) > 32'(MAX_STACKS));

  assign {rd_none, rd_below, rd_tag} = node_rdata;

  // Sequencer and command decision
  always_comb begin
    state_next = state;
    done       = 1'b0;
    fail       = 1'b0;
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    use_free   = !free_none;
    new_nd     = free_none ? NODE_W'(never_used) : free_idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (err) begin
          done = 1'b1;                      // ignored: sticky error
        end else if (bad_q) begin
          done = 1'b1;
          fail = 1'b1;
        end else if (cmd_q == CMD_PUSH) begin
          done = 1'b1;
          if (LIM_W'(total) >= LIM_W'(total_limit)) begin
            fail = 1'b1;
          end else if (!free_none) begin
            push_ok = 1'b1;
          end else if (never_used < CNT_W'(POOL_NODES)) begin
            push_ok = 1'b1;
          end else begin
            fail = 1'b1;                    // pool exhausted
          end
        end else if (!nonempty[s_q]) begin
          done = 1'b1;
          fail = 1'b1;                      // pop of an empty stack
        end else begin
          state_next = S_POP;               // fetch the top node
        end
      end
      S_POP: begin
        done = 1'b1;
        if (rd_tag != tag_q) begin
          fail = 1'b1;
        end else begin
          pop_ok = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (done) begin
      state_next = S_IDLE;
    end
  end

  // RAM access: top pointers read at acceptance; node RAM read at
  // acceptance for the free-list link, then at the top node for a pop.
  assign top_re    = accept;
  assign top_we    = push_ok || (pop_ok && !rd_none);
  assign top_waddr = s_q;
  assign top_wdata = push_ok ? new_nd : rd_below;

  assign node_re    = accept || (state_next == S_POP && state == S_READ);
  assign node_raddr = (state == S_IDLE) ? free_idx : top_rdata;
  assign node_we    = push_ok || pop_ok;
  assign node_waddr = push_ok ? new_nd : top_rdata;
  // Push links the new node to the old top; pop threads the node
  // onto the free list and keeps its tag.
  assign node_wdata = push_ok ? {!nonempty[s_q], top_rdata, tag_q}
                              : {free_none, free_idx, rd_tag};

  // Counters after this transaction
  assign err_next   = err || fail;
  assign total_next = push_ok ? total + CNT_W'(1) :
                      pop_ok  ? total - CNT_W'(1) : total;
  assign peak_next  = (!err && total_next > peak) ? total_next : peak;

  assign rsp_done.error_seen = err_next;
  assign rsp_done.total_held = OUT_CNT_W'(total_next);
  assign rsp_done.peak_held  = OUT_CNT_W'(peak_next);
  assign rsp_done.all_clear  = !err_next && (total_next == '0);

  assign rsp_pend.error_seen = err;
  assign rsp_pend.total_held = OUT_CNT_W'(total);
  assign rsp_pend.peak_held  = OUT_CNT_W'(peak);
  assign rsp_pend.all_clear  = !err && (total == '0);

  mssp_ram #(
    .DEPTH (MAX_STACKS),
    .WIDTH (NODE_W)
  ) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (top_waddr),
    .wdata (top_wdata),
    .re    (top_re),
    .raddr (STK_W'(s_num)),
    .rdata (top_rdata)
  );

  mssp_ram #(
    .DEPTH (POOL_NODES),
    .WIDTH (NWORD_W)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Latch the request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.command;
      s_q   <= STK_W'(s_num);
      bad_q <= range_bad;
      tag_q <= TAG_BITS'(req.item_tag);
    end
  end

  // Control, pool state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      err           <= 1'b0;
      total         <= '0;
      peak          <= '0;
      free_none     <= 1'b1;
      free_idx      <= '0;
      never_used    <= '0;
      nonempty      <= '0;
      stacks_in_use <= STACKS_IN_USE_RST;
      total_limit   <= TOTAL_LIMIT_RST;
    end else begin
      state <= state_next;
      if (done) begin
        err   <= err_next;
        total <= total_next;
        peak  <= peak_next;
      end
      if (push_ok) begin
        nonempty[s_q] <= 1'b1;
        if (use_free) begin
          free_none <= rd_none;             // advance the free list
          free_idx  <= rd_below;
        end else begin
          never_used <= never_used + CNT_W'(1);
        end
      end
      if (pop_ok) begin
        if (rd_none) begin
          nonempty[s_q] <= 1'b0;            // last node gone
        end
        free_none <= 1'b0;
        free_idx  <= top_rdata;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_STACKS_IN_USE: stacks_in_use <= cfg_data[STACK_NUM_W-1:0];
          REG_TOTAL_LIMIT:   total_limit   <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Response register with one pending slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (done) begin
      if (slot_free) begin
        rsp_valid <= 1'b1;
      end else begin
        pend <= 1'b1;
      end
    end else if (pend && slot_free) begin
      rsp_valid <= 1'b1;
      pend      <= 1'b0;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && slot_free) begin
      rsp <= rsp_done;
    end else if (!done && pend && slot_free) begin
      rsp <= rsp_pend;
    end
  end

  // Assertions
  a_pend_blocks: assert property (@(posedge clk) disable iff (rst)
    pend |-> !req_ready)
    else $error("request taken while a response is pending");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err |=> err)
    else $error("error flag cleared without reset");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    peak >= total)
    else $error("peak below current total");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (total <= CNT_W'(POOL_NODES)) && (never_used <= CNT_W'(POOL_NODES)))
    else $error("pool counters exceed pool size");

  a_clear_consistent: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.all_clear) |-> (!rsp.error_seen && rsp.total_held == '0))
    else $error("all-clear reported with items held or error set");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for multi_stack_shared_pool_core
// Sends push and pop transactions over valid/ready with bursty input and a
// stalling receiver. A model of the linked stacks and the shared node pool
// predicts every status transaction, which is then compared field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mssp_pkg::*;

  localparam int MAX_STACKS = 256;
  localparam int POOL_NODES = 1024;
  localparam int TAG_BITS   = 16;

  // Linked stacks over one shared node pool, plus the queue of status
  // transactions still owed by the block.
  class stack_pool_tracker;
    logic [TAG_BITS-1:0] node_tag [POOL_NODES];
    int   node_below [POOL_NODES];
    int   top_node [MAX_STACKS];
    bit   nonempty [MAX_STACKS];
    int   free_head;
    int   fresh_next;
    int   total;
    int   peak;
    bit   sticky_err;
    int   stacks_in_use;
    int   total_limit;
    rsp_t pending_status [$];
    int   failures;

    function new();
      foreach (node_tag[i]) begin
        node_tag[i]   = '0;
        node_below[i] = 0;
      end
      foreach (top_node[i]) begin
        top_node[i] = 0;
        nonempty[i] = 1'b0;
      end
      free_head     = POOL_NODES;
      fresh_next    = 0;
      total         = 0;
      peak          = 0;
      sticky_err    = 1'b0;
      stacks_in_use = STACKS_IN_USE_RST;
      total_limit   = TOTAL_LIMIT_RST;
      failures      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, int value);
      if (idx == REG_STACKS_IN_USE) begin
        stacks_in_use = value & 'h1FF;
      end else begin
        total_limit = value & 'h7FF;
      end
    endfunction

    // Returns 0 when the command fails.
    function bit apply_command(req_t r);
      int num;
      int s;
      int nd;
      int below;
      num = r.stack_number;
      if (num == 0 || num > stacks_in_use || num > MAX_STACKS) return 1'b0;
      s = num - 1;
      if (r.command == CMD_PUSH) begin
        if (total >= total_limit) return 1'b0;
        if (free_head < POOL_NODES) begin
          nd        = free_head;
          free_head = node_below[nd];
        end else if (fresh_next < POOL_NODES) begin
          nd = fresh_next;
          fresh_next++;
        end else begin
          return 1'b0;
        end
        node_tag[nd]   = r.item_tag;
        node_below[nd] = nonempty[s] ? top_node[s] : POOL_NODES;
        top_node[s]    = nd;
        nonempty[s]    = 1'b1;
        total++;
        return 1'b1;
      end
      if (!nonempty[s]) return 1'b0;
      nd = top_node[s];
      if (node_tag[nd] != r.item_tag) return 1'b0;
      below = node_below[nd];
      if (below < POOL_NODES) begin
        top_node[s] = below;
      end else begin
        nonempty[s] = 1'b0;
      end
      node_below[nd] = free_head;
      free_head      = nd;
      if (total > 0) total--;
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t s;
      if (!sticky_err) begin
        if (!apply_command(r)) sticky_err = 1'b1;
        if (total > peak) peak = total;
      end
      s.error_seen = sticky_err;
      s.total_held = OUT_CNT_W'(total);
      s.peak_held  = OUT_CNT_W'(peak);
      s.all_clear  = !sticky_err && total == 0;
      pending_status.push_back(s);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_status(rsp_t got);
      rsp_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: status transaction with nothing expected: %h", $time, got);
        failures++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("error_seen", want.error_seen, got.error_seen);
      compare_field("total_held", want.total_held, got.total_held);
      compare_field("peak_held", want.peak_held, got.peak_held);
      compare_field("all_clear", want.all_clear, got.all_clear);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stack_pool_tracker tracker;
  int burst_left = 0;

  multi_stack_shared_pool_core #(
    .MAX_STACKS(MAX_STACKS),
    .POOL_NODES(POOL_NODES),
    .TAG_BITS  (TAG_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs somewhere.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Check every status transaction as it is taken.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_status(rsp);
  end

  // Receiver: switch between always ready, coin flip and mostly stalled. Once,
  // early in the run, hold off for a long stretch so the block backs up and
  // stalls its request side while the sender keeps offering.
  initial begin
    int  seen;
    int  hold_left;
    int  mode;
    int  mode_left;
    bit  held_done;
    seen      = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    held_done = 1'b0;
    rsp_ready <= 1'b0;
    forever @(posedge clk) begin
      if (rsp_valid && rsp_ready) seen++;
      if (!held_done && seen >= 60) begin
        held_done = 1'b1;
        hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(1));
          default: rsp_ready <= ($urandom_range(4) == 0);
        endcase
      end
    end
  end

  // Sender pacing: bursts of random length, a random gap after each, and
  // often no gap at all so long back-to-back stretches occur too.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one request, hold it until taken, then log it with the tracker.
  // Call only in the time step of a rising edge.
  task automatic send_req(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    tracker.note_request(r);
    pace();
  endtask

  // Drop valid and wait until every status transaction has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tracker.write_register(idx, value);
  endtask

  function automatic req_t make_req(logic cmd, int num, logic [15:0] tag);
    req_t r;
    r.command      = cmd;
    r.stack_number = STACK_NUM_W'(num);
    r.item_tag     = tag;
    return r;
  endfunction

  // Pop that matches the current top of stack number num.
  function automatic req_t pop_of(int num);
    return make_req(CMD_POP, num, tracker.node_tag[tracker.top_node[num - 1]]);
  endfunction

  function automatic int usable_stacks();
    return (tracker.stacks_in_use < MAX_STACKS) ? tracker.stacks_in_use : MAX_STACKS;
  endfunction

  // Favour extremes and a few small values so equal tags pile up on a stack.
  function automatic logic [15:0] pick_tag();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Most pushes land on a few hot stacks so they grow deep.
  function automatic int pick_push_stack(int span);
    int hot;
    hot = (span < 3) ? span : 3;
    if ($urandom_range(2) != 0) return $urandom_range(1, hot);
    return $urandom_range(1, span);
  endfunction

  // Scan from a random start for a stack that holds something.
  function automatic int pick_full_stack(int span);
    int s;
    s = $urandom_range(0, span - 1);
    repeat (span) begin
      if (tracker.nonempty[s]) return s + 1;
      s = (s + 1) % span;
    end
    return 0;
  endfunction

  // A command that is sure to succeed in the current state.
  function automatic req_t next_legal(int push_pct);
    int span;
    bit can_push;
    bit can_pop;
    span     = usable_stacks();
    can_push = tracker.total < tracker.total_limit && tracker.total < POOL_NODES;
    can_pop  = tracker.total > 0;
    if (can_push && (!can_pop || $urandom_range(99) < push_pct)) begin
      return make_req(CMD_PUSH, pick_push_stack(span), pick_tag());
    end
    return pop_of(pick_full_stack(span));
  endfunction

  // Under the old settings, empty the stacks the new ones cannot reach and
  // bring the total down to the new limit, so no command has to fail later.
  task automatic settle_for(int new_span, int new_limit);
    for (int s = new_span; s < MAX_STACKS; s++) begin
      while (tracker.nonempty[s]) send_req(pop_of(s + 1));
    end
    while (tracker.total > new_limit) send_req(pop_of(pick_full_stack(usable_stacks())));
  endtask

  task automatic run_phase(int span_reg, int limit, int count, int push_pct);
    settle_for((span_reg < MAX_STACKS) ? span_reg : MAX_STACKS, limit);
    wait_drained();
    write_reg(REG_STACKS_IN_USE, span_reg);
    write_reg(REG_TOTAL_LIMIT, limit);
    repeat (count) send_req(next_legal(push_pct));
  endtask

  // The error flag is sticky and reset comes only once, so pick one way to
  // fail at random and leave it for the very end.
  task automatic provoke_error();
    req_t r;
    int   kind;
    int   s;
    r    = make_req(CMD_PUSH, 1, pick_tag());
    kind = $urandom_range(7);
    wait_drained();
    case (kind)
      0: r.stack_number = '0;
      1: begin
        s = $urandom_range(1, 255);
        write_reg(REG_STACKS_IN_USE, s);
        r.stack_number = STACK_NUM_W'($urandom_range(s + 1, 511));
      end
      2: begin
        write_reg(REG_STACKS_IN_USE, 511);
        r.stack_number = STACK_NUM_W'($urandom_range(257, 511));
      end
      3: begin
        write_reg(REG_STACKS_IN_USE, 0);
        r.command      = $urandom_range(1) ? CMD_POP : CMD_PUSH;
        r.stack_number = STACK_NUM_W'($urandom_range(1, 256));
      end
      4: write_reg(REG_TOTAL_LIMIT, tracker.total);
      5: begin
        // limit above the pool: fill every node, then one more push
        write_reg(REG_TOTAL_LIMIT, $urandom_range(1025, 2047));
        while (tracker.total < POOL_NODES) send_req(next_legal(100));
      end
      6: begin
        // pop an empty stack; fall back to stack zero if all are in use
        r.command      = CMD_POP;
        r.stack_number = '0;
        s = $urandom_range(0, MAX_STACKS - 1);
        repeat (MAX_STACKS) begin
          if (!tracker.nonempty[s]) r.stack_number = STACK_NUM_W'(s + 1);
          s = (s + 1) % MAX_STACKS;
        end
      end
      default: begin
        // pop with a tag one bit off the top
        if (tracker.total == 0) send_req(next_legal(100));
        r = pop_of(pick_full_stack(usable_stacks()));
        r.item_tag ^= 16'(1 << $urandom_range(15));
      end
    endcase
    send_req(r);
  endtask

  initial begin
    req_t r;
    tracker = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: first and last stacks, extreme tags, node reuse from the
    // free list, and a final pop that leaves everything empty.
    send_req(make_req(CMD_PUSH, 1, 16'h0000));
    send_req(make_req(CMD_PUSH, 256, 16'hFFFF));
    send_req(make_req(CMD_PUSH, 1, 16'hFFFF));
    send_req(make_req(CMD_PUSH, 256, 16'h0000));
    send_req(make_req(CMD_PUSH, 255, 16'h5A5A));
    send_req(make_req(CMD_PUSH, 128, 16'hA5A5));
    send_req(make_req(CMD_POP, 128, 16'hA5A5));
    send_req(make_req(CMD_POP, 1, 16'hFFFF));
    send_req(make_req(CMD_PUSH, 1, 16'h1234));
    send_req(make_req(CMD_POP, 255, 16'h5A5A));
    send_req(make_req(CMD_POP, 256, 16'h0000));
    send_req(make_req(CMD_POP, 256, 16'hFFFF));
    send_req(make_req(CMD_POP, 1, 16'h1234));
    send_req(make_req(CMD_POP, 1, 16'h0000));

    // Random well-formed traffic under a series of settings.
    run_phase(4, 1024, 150, 60);
    run_phase(1, 1, 80, 50);
    run_phase(256, 37, 180, 55);
    run_phase(511, 300, 180, 60);
    run_phase(2, 8, 100, 50);

    // Fill the whole pool, then churn near the top.
    run_phase(256, 1024, 0, 100);
    while (tracker.total < POOL_NODES) send_req(next_legal(100));
    repeat (100) send_req(next_legal(40));

    // One failure, then noise that the block must ignore.
    provoke_error();
    repeat (40) begin
      r.command      = $urandom_range(1) ? CMD_POP : CMD_PUSH;
      r.stack_number = STACK_NUM_W'($urandom_range(0, 511));
      r.item_tag     = 16'($urandom);
      send_req(r);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
